@@ sv/iou_pkg.sv @@
// Shared widths, constants, register codes and pipeline types for the IoU cost block.
package iou_pkg;

	localparam int COORD_W = 16;
	localparam int OVL_W   = COORD_W + 2;
	localparam int AREA_W  = 2 * COORD_W;
	localparam int UNI_W   = AREA_W + 1;
	localparam int FRAC_W  = 16;
	localparam int COST_W  = FRAC_W + 1;
	localparam int STALE_W = 8;
	localparam int IDX_W   = 6;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;

	localparam int DIV_STEPS = FRAC_W;

	localparam logic [COST_W-1:0] Q_ONE = COST_W'(1) << FRAC_W;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = COST_W;

	localparam logic [COST_W-1:0]  GATED_COST_RST  = '1;
	localparam logic [STALE_W-1:0] STALE_LIMIT_RST = STALE_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GATED_COST  = 1'b0,
		REG_STALE_LIMIT = 1'b1
	} cfg_reg_t;

	// Side information that rides along with every pair.
	typedef struct packed {
		logic             gated;
		logic             zero;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} meta_t;

	// One slot of the restoring divider: partial remainder, divisor, quotient so far.
	typedef struct packed {
		logic [UNI_W-1:0]  rem;
		logic [UNI_W-1:0]  den;
		logic [COST_W-1:0] quo;
		meta_t             meta;
	} div_t;

	// Finished result as it leaves the pipeline.
	typedef struct packed {
		logic [COST_W-1:0] cost;
		logic              gated;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
	} res_t;

endpackage

@@ sv/iou_if.sv @@
// Channel interfaces: box pairs in, cost results out.
interface iou_in_if import iou_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] track_left;
	logic signed [COORD_W-1:0] track_top;
	logic        [COORD_W-1:0] track_width;
	logic        [COORD_W-1:0] track_height;
	logic        [STALE_W-1:0] track_stale;
	logic signed [COORD_W-1:0] det_left;
	logic signed [COORD_W-1:0] det_top;
	logic        [COORD_W-1:0] det_width;
	logic        [COORD_W-1:0] det_height;
	logic        [IDX_W-1:0]   row_index;
	logic        [IDX_W-1:0]   col_index;

	modport source (
		output valid, track_left, track_top, track_width, track_height, track_stale,
		output det_left, det_top, det_width, det_height, row_index, col_index,
		input  ready
	);
	modport sink (
		input  valid, track_left, track_top, track_width, track_height, track_stale,
		input  det_left, det_top, det_width, det_height, row_index, col_index,
		output ready
	);
endinterface

interface iou_out_if import iou_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [COST_W-1:0] cost;
	logic              gated;
	logic [IDX_W-1:0]  row_out;
	logic [IDX_W-1:0]  col_out;

	modport source (output valid, cost, gated, row_out, col_out, input ready);
	modport sink (input valid, cost, gated, row_out, col_out, output ready);
endinterface

@@ sv/iou_front.sv @@
// Front pipeline: overlap, areas, union and first quotient bit over four stages.
module iou_front import iou_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [STALE_W-1:0] stale_limit,
	iou_in_if.sink             pair,
	output logic               valid_s4,
	output div_t               data_s4
);

	function automatic logic [COORD_W-1:0] overlap(
		input logic signed [COORD_W-1:0] a0,
		input logic        [COORD_W-1:0] alen,
		input logic signed [COORD_W-1:0] b0,
		input logic        [COORD_W-1:0] blen
	);
		logic signed [OVL_W-1:0] a1;
		logic signed [OVL_W-1:0] b1;
		logic signed [OVL_W-1:0] lo;
		logic signed [OVL_W-1:0] hi;
		logic signed [OVL_W-1:0] d;
		a1 = OVL_W'(a0) + $signed({2'b00, alen});
		b1 = OVL_W'(b0) + $signed({2'b00, blen});
		lo = (a0 > b0) ? OVL_W'(a0) : OVL_W'(b0);
		hi = (a1 < b1) ? a1 : b1;
		d  = hi - lo;
		return (hi > lo) ? d[COORD_W-1:0] : '0;
	endfunction

	logic               valid_s1, valid_s2, valid_s3;
	logic [COORD_W-1:0] iw_s1, ih_s1, tw_s1, th_s1, dw_s1, dh_s1;
	meta_t              meta_s1, meta_s2, meta_s3;
	logic [AREA_W-1:0]  inter_s2, ta_s2, da_s2;
	logic [UNI_W-1:0]   sum_s3;
	logic [AREA_W-1:0]  inter_s3;
	logic [UNI_W-1:0]   uni;
	logic [UNI_W-1:0]   num;
	logic               no_inter;

	assign pair.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pair.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// s1: edge overlap per axis, gate check
	always_ff @(posedge clk) begin
		if (en) begin
			iw_s1 <= overlap(pair.track_left, pair.track_width, pair.det_left, pair.det_width);
			ih_s1 <= overlap(pair.track_top, pair.track_height, pair.det_top, pair.det_height);
			tw_s1 <= pair.track_width;
			th_s1 <= pair.track_height;
			dw_s1 <= pair.det_width;
			dh_s1 <= pair.det_height;
			meta_s1.gated <= (pair.track_stale > stale_limit);
			meta_s1.zero  <= 1'b0;
			meta_s1.row   <= IDX_W'(pair.row_index % MAX_ROWS);
			meta_s1.col   <= IDX_W'(pair.col_index % MAX_COLS);
		end
	end

	// s2: intersection and both areas
	always_ff @(posedge clk) begin
		if (en) begin
			inter_s2 <= iw_s1 * ih_s1;
			ta_s2    <= tw_s1 * th_s1;
			da_s2    <= dw_s1 * dh_s1;
			meta_s2  <= meta_s1;
		end
	end

	// s3: sum of areas
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3   <= UNI_W'(ta_s2) + UNI_W'(da_s2);
			inter_s3 <= inter_s2;
			meta_s3  <= meta_s2;
		end
	end

	// s4: union, dividend and the weight-one quotient bit.
	// The dividend reaches the union only when nothing overlaps.
	assign uni      = sum_s3 - UNI_W'(inter_s3);
	assign num      = sum_s3 - {inter_s3, 1'b0};
	assign no_inter = (inter_s3 == '0);

	always_ff @(posedge clk) begin
		if (en) begin
			data_s4.rem        <= no_inter ? '0 : num;
			data_s4.den        <= uni;
			data_s4.quo        <= COST_W'(no_inter);
			data_s4.meta.gated <= meta_s3.gated;
			data_s4.meta.zero  <= (sum_s3 == '0);
			data_s4.meta.row   <= meta_s3.row;
			data_s4.meta.col   <= meta_s3.col;
		end
	end

endmodule

@@ sv/iou_div_step.sv @@
// One registered step of the restoring divider: one quotient bit per stage.
module iou_div_step import iou_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_i,
	input  div_t data_i,
	output logic valid_s1,
	output div_t data_s1
);

	logic [UNI_W:0]   twice;
	logic [UNI_W+1:0] diff;
	logic             ge;

	assign twice = {data_i.rem, 1'b0};
	assign diff  = {1'b0, twice} - {2'b00, data_i.den};
	assign ge    = ~diff[UNI_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1.rem  <= ge ? diff[UNI_W-1:0] : twice[UNI_W-1:0];
			data_s1.den  <= data_i.den;
			data_s1.quo  <= {data_i.quo[COST_W-2:0], ge};
			data_s1.meta <= data_i.meta;
		end
	end

`ifndef ASSERT_OFF
	// Partial remainder stays below the divisor unless the union is empty
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !data_s1.meta.zero |-> data_s1.rem < data_s1.den)
		else $error("divider remainder not below divisor");
`endif

endmodule

@@ sv/iou_skid.sv @@
// Output register with one spare slot so the pipeline can run one beat past a stall.
module iou_skid import iou_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	input  res_t       data,
	output logic       advance,
	iou_out_if.source  result
);

	logic out_valid_q;
	logic spare_valid_q;
	res_t out_q;
	res_t spare_q;

	assign advance = ~spare_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else if (spare_valid_q) begin
			if (result.ready) begin
				spare_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || result.ready) begin
			out_valid_q <= valid;
		end else begin
			spare_valid_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (spare_valid_q) begin
			if (result.ready) begin
				out_q <= spare_q;
			end
		end else if (!out_valid_q || result.ready) begin
			out_q <= data;
		end else begin
			spare_q <= data;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.cost    = out_q.cost;
	assign result.gated   = out_q.gated;
	assign result.row_out = out_q.row;
	assign result.col_out = out_q.col;

`ifndef ASSERT_OFF
	// Spare only fills behind a held output beat
	a_spare_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		spare_valid_q |-> out_valid_q)
		else $error("spare slot full with output empty");
`endif

endmodule

@@ sv/iou_gated_cost.sv @@
// Top level: pipelined one-minus-IoU cost with stale-track gating.
//
//  channel  | dir | beat contents
//  ---------+-----+-------------------------------------------------------------
//  pair     | in  | track box, track stale count, detection box, row/col index
//  result   | out | cost (Q1.16), gated flag, row_out, col_out
//  cfg      | in  | cfg_we, cfg_index, cfg_wdata; write-only, no wait
//
// One pair enters per cycle unless a stall freezes the pipeline. A taken pair passes
// four front stages (overlap, products, area sum, union), sixteen divider
// stages that each resolve one quotient bit, and the output register.
// Reset clears all valid bits and loads gated_cost = 0x1FFFF, stale_limit = 1.
// A stall on result freezes the whole pipeline once the spare slot behind the
// output register has filled; pair.ready stays low for as long as it is full.
module iou_gated_cost import iou_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	iou_in_if.sink                pair,
	iou_out_if.source             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [COST_W-1:0]  gated_cost_q;
	logic [STALE_W-1:0] stale_limit_q;

	logic en;
	logic valid_chain [DIV_STEPS+1];
	div_t data_chain  [DIV_STEPS+1];
	res_t res;

	// Configuration registers; users must write only while the pipe is empty (not enforced)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gated_cost_q  <= GATED_COST_RST;
			stale_limit_q <= STALE_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GATED_COST: begin
					gated_cost_q <= cfg_wdata[COST_W-1:0];
				end
				REG_STALE_LIMIT: begin
					stale_limit_q <= cfg_wdata[STALE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Geometry, areas and union; also drives pair.ready from the shared enable
	iou_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.stale_limit (stale_limit_q),
		.pair        (pair),
		.valid_s4    (valid_chain[0]),
		.data_s4     (data_chain[0])
	);

	// Restoring divider, one bit per stage, most significant fraction bit first
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		iou_div_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_i  (valid_chain[k]),
			.data_i   (data_chain[k]),
			.valid_s1 (valid_chain[k+1]),
			.data_s1  (data_chain[k+1])
		);
	end

	// Gated tracks take the configured cost; an empty union reads as cost 1.0
	always_comb begin
		res.gated = data_chain[DIV_STEPS].meta.gated;
		res.row   = data_chain[DIV_STEPS].meta.row;
		res.col   = data_chain[DIV_STEPS].meta.col;
		if (data_chain[DIV_STEPS].meta.gated) begin
			res.cost = gated_cost_q;
		end else if (data_chain[DIV_STEPS].meta.zero) begin
			res.cost = Q_ONE;
		end else begin
			res.cost = data_chain[DIV_STEPS].quo;
		end
	end

	iou_skid u_skid (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (valid_chain[DIV_STEPS]),
		.data    (res),
		.advance (en),
		.result  (result)
	);

`ifndef ASSERT_OFF
	// An accepted pair shows up in the first stage on the next edge
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		pair.valid && pair.ready |=> valid_chain[0] || u_front.valid_s1)
		else $error("accepted pair missing from first stage");

	// An ungated cost never exceeds one
	a_cost_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.gated |-> result.cost <= Q_ONE)
		else $error("ungated cost above 1.0");

	// Input is refused only while the pipeline is frozen
	a_ready_en: assert property (@(posedge clk) disable iff (!arst_n)
		!pair.ready |-> !en)
		else $error("ready low with pipeline advancing");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the IoU cost block: a directed table, then random box pairs.
module tb_top;
	import iou_pkg::*;

	// One box pair as it goes onto the pair channel.
	typedef struct {
		logic signed [COORD_W-1:0] track_left;
		logic signed [COORD_W-1:0] track_top;
		logic        [COORD_W-1:0] track_width;
		logic        [COORD_W-1:0] track_height;
		logic        [STALE_W-1:0] track_stale;
		logic signed [COORD_W-1:0] det_left;
		logic signed [COORD_W-1:0] det_top;
		logic        [COORD_W-1:0] det_width;
		logic        [COORD_W-1:0] det_height;
		logic        [IDX_W-1:0]   row_index;
		logic        [IDX_W-1:0]   col_index;
	} box_pair_t;

	// Directed row: the pair, plus cost and gated flag where they are obvious by hand.
	typedef struct {
		box_pair_t         pair;
		bit                known;
		logic [COST_W-1:0] cost;
		logic              gated;
	} pair_case_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	iou_in_if  pair_bus ();
	iou_out_if cost_bus ();

	iou_gated_cost dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pair      (pair_bus),
		.result    (cost_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow of the register file; only touched while the pipeline is empty.
	logic [COST_W-1:0]  gated_cost_q  = GATED_COST_RST;
	logic [STALE_W-1:0] stale_limit_q = STALE_LIMIT_RST;

	res_t cost_due [$];   // costs still owed by the pipeline, oldest first
	int   err_count = 0;
	bit   calm      = 1'b0; // when set, neither side idles

	// Hand-checked rows sit under the reset registers (gated_cost all ones, stale_limit 1).
	pair_case_t directed_cases [20] = '{
		// identical boxes: no cost at all
		'{'{10, 10, 20, 20, 0, 10, 10, 20, 20, 0, 0}, 1, 0, 0},
		// far apart: full cost
		'{'{0, 0, 10, 10, 0, 100, 100, 10, 10, 63, 63}, 1, 65536, 0},
		// both boxes empty: zero union reads as cost 1.0
		'{'{5, 5, 0, 0, 0, 5, 5, 0, 0, 1, 2}, 1, 65536, 0},
		// zero-width strips, stale count right at the limit, still not gated
		'{'{0, 0, 0, 5, 1, 0, 0, 0, 5, 2, 1}, 1, 65536, 0},
		// stale just past the limit: gated, geometry ignored
		'{'{0, 0, 10, 10, 2, 0, 0, 10, 10, 5, 40}, 1, 131071, 1},
		'{'{0, 0, 10, 10, 255, 3, 3, 4, 4, 42, 21}, 1, 131071, 1},
		// largest boxes at both coordinate ends
		'{'{-32768, -32768, 65535, 65535, 0, -32768, -32768, 65535, 65535, 21, 42}, 1, 0, 0},
		'{'{32767, 32767, 65535, 65535, 1, 32767, 32767, 65535, 65535, 62, 1}, 1, 0, 0},
		// full-range track ends exactly where the detection starts
		'{'{-32768, -32768, 65535, 1, 0, 32767, -32768, 65535, 1, 1, 62}, 1, 65536, 0},
		// touching edges share no area
		'{'{0, 0, 10, 10, 0, 10, 0, 10, 10, 3, 4}, 1, 65536, 0},
		// contained box: 1 - 16/64
		'{'{0, 0, 4, 4, 0, 0, 0, 8, 8, 6, 7}, 1, 49152, 0},
		// one box empty, the other not
		'{'{0, 0, 0, 0, 0, 0, 0, 10, 10, 8, 9}, 1, 65536, 0},
		// half overlap: 1 - 2/4
		'{'{0, 0, 3, 1, 0, 1, 0, 3, 1, 10, 11}, 1, 32768, 0},
		// thirds: the quotient truncates
		'{'{0, 0, 2, 1, 0, 1, 0, 2, 1, 12, 13}, 1, 43690, 0},
		'{'{1, 0, 2, 1, 0, 0, 0, 2, 1, 14, 15}, 1, 43690, 0},
		// mixed geometry, left to the predictor
		'{'{-100, -50, 300, 200, 1, -20, 10, 150, 400, 16, 17}, 0, 0, 0},
		'{'{32767, -32768, 1, 65535, 0, 32000, -32000, 1000, 3, 31, 32}, 0, 0, 0},
		'{'{-1, -1, 65535, 2, 0, 12345, 0, 7, 1, 47, 48}, 0, 0, 0},
		'{'{1000, 2000, 333, 777, 1, 1100, 2100, 500, 100, 55, 56}, 0, 0, 0},
		'{'{-32768, 32767, 65535, 65535, 0, -32768, 32767, 1, 1, 60, 3}, 0, 0, 0}
	};

	// 50 MHz clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#20_000_000;
		$display("tb_top: errors");
		$finish;
	end

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Length of overlap of two 1-D spans, clamped at zero.
	function automatic longint span_overlap(longint a0, longint alen, longint b0, longint blen);
		longint lo;
		longint hi;
		lo = (a0 > b0) ? a0 : b0;
		hi = (a0 + alen < b0 + blen) ? a0 + alen : b0 + blen;
		return (hi > lo) ? hi - lo : 0;
	endfunction

	// Expected result of one pair under the current shadow registers.
	function automatic res_t predict_cost(box_pair_t p);
		res_t   r;
		longint ow;
		longint oh;
		longint inter;
		longint uni;
		r.row = IDX_W'(p.row_index % MAX_ROWS);
		r.col = IDX_W'(p.col_index % MAX_COLS);
		if (p.track_stale > stale_limit_q) begin
			r.cost  = gated_cost_q;
			r.gated = 1'b1;
		end else begin
			ow    = span_overlap(p.track_left, p.track_width, p.det_left, p.det_width);
			oh    = span_overlap(p.track_top, p.track_height, p.det_top, p.det_height);
			inter = ow * oh;
			uni   = longint'(p.track_width) * longint'(p.track_height)
				+ longint'(p.det_width) * longint'(p.det_height) - inter;
			if (uni == 0)
				r.cost = Q_ONE;
			else
				r.cost = COST_W'(((uni - inter) << FRAC_W) / uni);
			r.gated = 1'b0;
		end
		return r;
	endfunction

	// Corner values: sizes 0/1/max/max-1, positions at both ends and around zero.
	function automatic logic [COORD_W-1:0] extreme_value(bit as_size);
		case ($urandom_range(0, 3))
			0: return as_size ? 16'h0000 : 16'h8000;
			1: return as_size ? 16'h0001 : 16'h7FFF;
			2: return 16'hFFFF;
			default: return as_size ? 16'hFFFE : 16'h0000;
		endcase
	endfunction

	// Random pair. Most pairs overlap so the divider sees real fractions; the rest
	// are empty boxes, corner values, or raw noise.
	function automatic box_pair_t random_pair();
		box_pair_t p;
		int        shape;
		int        k;
		int        span;
		int        off;
		shape          = $urandom_range(0, 99);
		p.track_left   = COORD_W'($urandom);
		p.track_top    = COORD_W'($urandom);
		p.track_width  = COORD_W'($urandom);
		p.track_height = COORD_W'($urandom);
		p.det_left     = COORD_W'($urandom);
		p.det_top      = COORD_W'($urandom);
		p.det_width    = COORD_W'($urandom);
		p.det_height   = COORD_W'($urandom);
		p.row_index    = IDX_W'($urandom);
		p.col_index    = IDX_W'($urandom);
		if (shape < 60) begin
			// jitter the detection around the track at a random scale
			k              = $urandom_range(1, 16);
			span           = (1 << k) - 1;
			p.track_width  = COORD_W'($urandom_range(0, span));
			p.track_height = COORD_W'($urandom_range(0, span));
			p.det_width    = COORD_W'($urandom_range(0, span));
			p.det_height   = COORD_W'($urandom_range(0, span));
			off            = int'($urandom_range(0, span)) - span / 2;
			p.det_left     = COORD_W'(int'(p.track_left) + off);
			off            = int'($urandom_range(0, span)) - span / 2;
			p.det_top      = COORD_W'(int'(p.track_top) + off);
		end else if (shape < 70) begin
			// empty boxes, down to a zero union
			case ($urandom_range(0, 3))
				0: p.track_width = '0;
				1: p.det_height = '0;
				2: begin
					p.track_height = '0;
					p.det_width    = '0;
				end
				default: begin
					p.track_width  = '0;
					p.track_height = '0;
					p.det_width    = '0;
					p.det_height   = '0;
				end
			endcase
		end else if (shape < 85) begin
			p.track_left   = extreme_value(1'b0);
			p.track_top    = extreme_value(1'b0);
			p.track_width  = extreme_value(1'b1);
			p.track_height = extreme_value(1'b1);
			p.det_left     = extreme_value(1'b0);
			p.det_top      = extreme_value(1'b0);
			p.det_width    = extreme_value(1'b1);
			p.det_height   = extreme_value(1'b1);
		end
		// keep most tracks fresh, hover some around the limit, scatter the rest
		case ($urandom_range(0, 3))
			0, 1: p.track_stale = STALE_W'($urandom_range(0, 3));
			2: p.track_stale = STALE_W'(int'(stale_limit_q) + int'($urandom_range(0, 2)) - 1);
			default: p.track_stale = STALE_W'($urandom);
		endcase
		return p;
	endfunction

	// Offer one pair after a random gap; hold it until the block takes it.
	// A zero gap keeps valid high straight into the next beat.
	task automatic send_pair(input box_pair_t p, input res_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			pair_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pair_bus.track_left   <= p.track_left;
		pair_bus.track_top    <= p.track_top;
		pair_bus.track_width  <= p.track_width;
		pair_bus.track_height <= p.track_height;
		pair_bus.track_stale  <= p.track_stale;
		pair_bus.det_left     <= p.det_left;
		pair_bus.det_top      <= p.det_top;
		pair_bus.det_width    <= p.det_width;
		pair_bus.det_height   <= p.det_height;
		pair_bus.row_index    <= p.row_index;
		pair_bus.col_index    <= p.col_index;
		pair_bus.valid        <= 1'b1;
		do @(posedge clk); while (!pair_bus.ready);
		cost_due = {cost_due, want};
	endtask

	task automatic run_random(input int count);
		box_pair_t p;
		for (int i = 0; i < count; i++) begin
			p = random_pair();
			send_pair(p, predict_cost(p));
		end
	endtask

	// Drop valid and wait for the pipeline to hand back everything it owes.
	// Every pair yields a result, so an empty queue means an empty pipeline.
	task automatic settle();
		pair_bus.valid <= 1'b0;
		while (cost_due.size() != 0) @(posedge clk);
	endtask

	// Write both registers on back-to-back edges; the enable stays high across them.
	task automatic load_config(input logic [CFG_DATA_W-1:0] cost_val,
			input logic [CFG_DATA_W-1:0] limit_raw);
		cfg_we    <= 1'b1;
		cfg_index <= REG_GATED_COST;
		cfg_wdata <= cost_val;
		@(posedge clk);
		cfg_index <= REG_STALE_LIMIT;
		cfg_wdata <= limit_raw;
		@(posedge clk);
		cfg_we        <= 1'b0;
		gated_cost_q  = cost_val;
		stale_limit_q = limit_raw[STALE_W-1:0];
	endtask

	// Result side: stall at random, with ready held high for runs in between.
	initial begin
		int hold;
		cost_bus.ready <= 1'b0;
		@(posedge clk);
		forever begin
			hold = pick_gap();
			if (hold > 0) begin
				cost_bus.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			cost_bus.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// Compare every result beat against the oldest owed cost.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && cost_bus.valid && cost_bus.ready) begin
			if (cost_due.size() == 0) begin
				$error("result beat with nothing owed: cost %0d row %0d col %0d",
					cost_bus.cost, cost_bus.row_out, cost_bus.col_out);
				err_count++;
			end else begin
				want = cost_due.pop_front();
				if (cost_bus.cost !== want.cost) begin
					$error("cost: expected %0d, got %0d", want.cost, cost_bus.cost);
					err_count++;
				end
				if (cost_bus.gated !== want.gated) begin
					$error("gated: expected %0d, got %0d", want.gated, cost_bus.gated);
					err_count++;
				end
				if (cost_bus.row_out !== want.row) begin
					$error("row_out: expected %0d, got %0d", want.row, cost_bus.row_out);
					err_count++;
				end
				if (cost_bus.col_out !== want.col) begin
					$error("col_out: expected %0d, got %0d", want.col, cost_bus.col_out);
					err_count++;
				end
			end
		end
	end

	// Stimulus sequence.
	initial begin
		res_t want;
		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_index             <= REG_GATED_COST;
		cfg_wdata             <= '0;
		pair_bus.valid        <= 1'b0;
		pair_bus.track_left   <= '0;
		pair_bus.track_top    <= '0;
		pair_bus.track_width  <= '0;
		pair_bus.track_height <= '0;
		pair_bus.track_stale  <= '0;
		pair_bus.det_left     <= '0;
		pair_bus.det_top      <= '0;
		pair_bus.det_width    <= '0;
		pair_bus.det_height   <= '0;
		pair_bus.row_index    <= '0;
		pair_bus.col_index    <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table under the reset registers.
		foreach (directed_cases[i]) begin
			if (directed_cases[i].known) begin
				want.cost  = directed_cases[i].cost;
				want.gated = directed_cases[i].gated;
				want.row   = directed_cases[i].pair.row_index;
				want.col   = directed_cases[i].pair.col_index;
			end else begin
				want = predict_cost(directed_cases[i].pair);
			end
			send_pair(directed_cases[i].pair, want);
		end
		settle();

		// Lowest settings: zero gated cost, gate anything with a nonzero stale count.
		load_config('0, '0);
		run_random(150);
		settle();

		// Highest settings with upper data bits set on the limit write, which must
		// drop them; nothing gates at 255. Run flat out with no idling either side.
		load_config('1, '1);
		calm = 1'b1;
		run_random(100);
		settle();
		calm = 1'b0;

		// Random gated cost, small limit, junk in the unused data bits.
		load_config(CFG_DATA_W'($urandom_range(0, 131071)),
			{9'($urandom), 8'($urandom_range(0, 8))});
		run_random(200);
		settle();

		// Gated cost equal to 1.0, back to the reset limit.
		load_config(Q_ONE, CFG_DATA_W'(STALE_LIMIT_RST));
		run_random(150);
		settle();

		// Let a stray extra beat show up if the block makes one.
		repeat (30) @(posedge clk);
		if (err_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/iou_pkg.sv
sv/iou_if.sv
sv/iou_front.sv
sv/iou_div_step.sv
sv/iou_skid.sv
sv/iou_gated_cost.sv
tb/sv/tb_top.sv
